// ===== hdl/tlc_pkg.sv =====
// Shared types, constants and LRU helpers for the two-level cache model.
package tlc_pkg;

  localparam int unsigned NumWays     = 8;
  localparam int unsigned FirstSets   = 64;
  localparam int unsigned SecondSets  = 512;
  localparam int unsigned OffsetBits  = 6;
  localparam int unsigned AddrBits    = 48;
  localparam int unsigned TotalBits   = 48;
  localparam int unsigned NumTotals   = 7;

  localparam int unsigned WayBits     = $clog2(NumWays);
  localparam int unsigned RankBits    = 4;
  localparam int unsigned BlockBits   = AddrBits - OffsetBits;
  localparam int unsigned Set1Bits    = $clog2(FirstSets);
  localparam int unsigned Set2Bits    = $clog2(SecondSets);
  localparam int unsigned Tag1Bits    = BlockBits - Set1Bits;
  localparam int unsigned Tag2Bits    = BlockBits - Set2Bits;
  localparam int unsigned OutBits     = 5 + NumTotals * TotalBits;
  localparam int unsigned OutBytes    = (OutBits + 7) / 8;
  localparam int unsigned InBytes     = (AddrBits + 7) / 8;

  localparam logic [TotalBits-1:0] TotalMax = {TotalBits{1'b1}};

  // Totals slots
  localparam int unsigned TotReads    = 0;
  localparam int unsigned TotWrites   = 1;
  localparam int unsigned TotL1Hits   = 2;
  localparam int unsigned TotL1Misses = 3;
  localparam int unsigned TotL2Hits   = 4;
  localparam int unsigned TotL2Misses = 5;
  localparam int unsigned TotWbacks   = 6;

  typedef logic [WayBits-1:0]               way_t;
  typedef logic [NumWays-1:0]               mask_t;
  typedef logic [NumWays-1:0][RankBits-1:0] order_t;

  typedef struct packed {
    logic [NumWays-1:0][Tag1Bits-1:0] tags;
    mask_t                            valid;
    mask_t                            dirty;
    order_t                           order;
  } l1_row_t;

  typedef struct packed {
    logic [NumWays-1:0][Tag2Bits-1:0] tags;
    mask_t                            valid;
    mask_t                            dirty;
    order_t                           order;
  } l2_row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_VREQ,
    ST_VMOD,
    ST_FIN
  } state_e;

  // Rank k holds way k
  function automatic order_t order_init();
    order_t o;
    for (int k = 0; k < NumWays; k++) begin
      o[k] = RankBits'(k);
    end
    return o;
  endfunction

  // Move a way to rank 0, shifting the ranks above it down by one
  function automatic order_t make_mru(order_t old, way_t way);
    order_t res;
    logic   found;
    int     rank;
    res   = old;
    found = 1'b0;
    rank  = NumWays - 1;
    for (int r = 0; r < NumWays; r++) begin
      if (!found && old[r] == RankBits'(way)) begin
        found = 1'b1;
        rank  = r;
      end
    end
    for (int r = 1; r < NumWays; r++) begin
      if (r <= rank) res[r] = old[r-1];
    end
    res[0] = RankBits'(way);
    return res;
  endfunction

  // Lowest invalid way, else the LRU way
  function automatic way_t pick_victim(mask_t valid, order_t order);
    way_t w;
    logic found;
    found = 1'b0;
    w     = order[NumWays-1] < RankBits'(NumWays) ?
            order[NumWays-1][WayBits-1:0] : way_t'(NumWays - 1);
    for (int k = 0; k < NumWays; k++) begin
      if (!found && !valid[k]) begin
        found = 1'b1;
        w     = way_t'(k);
      end
    end
    return w;
  endfunction

  // Saturating add of a small count
  function automatic logic [TotalBits-1:0] sat_add(logic [TotalBits-1:0] t, logic [1:0] k);
    logic [TotalBits:0] s;
    s = {1'b0, t} + {{(TotalBits-1){1'b0}}, k};
    return s[TotalBits] ? TotalMax : s[TotalBits-1:0];
  endfunction

endpackage

// ===== hdl/two_level_lru_cache_model_core.sv =====
// Two-level write-back LRU cache model: set memories, sequencer and batch totals.
//
// Each beat on the slave side is one access (tuser = write flag, tlast = end of
// batch, tdata = byte address); each master beat carries the hit flags, the
// memory writeback count and the seven saturating batch totals. An L1 hit or an
// L1 miss with a clean victim goes from ST_LOOK to ST_FIN, which registers its
// result, and then takes the next beat in ST_IDLE; a miss with a dirty victim
// also passes ST_VREQ and ST_VMOD between ST_LOOK and ST_FIN: both levels
// keep one row per set in a single-port-write memory with a registered read, and
// the dirty victim needs a second L2 row read after the fill row is written back.
// A result held on the master side stalls the next access in its final cycle.
// After reset the block sweeps the 512 L2 rows, one per cycle, before it accepts
// its first beat.
module two_level_lru_cache_model_core
  import tlc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [InBytes*8-1:0]    s_axis_tdata,   // address
  input  logic [0:0]              s_axis_tuser,   // req_type
  input  logic                    s_axis_tlast,   // last_in_batch
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutBytes*8-1:0]   m_axis_tdata    // l1_hit, l2_hit, l2_miss,
                                                  // memory_writebacks, total_reads,
                                                  // total_writes, total_l1_hits,
                                                  // total_l1_misses, total_l2_hits,
                                                  // total_l2_misses, total_writebacks
);

  state_e state_q, state_d;

  // Latched access
  logic                  wr_q, last_q;
  logic [BlockBits-1:0]  blk_q;
  logic                  l1h_q, l2h_q, l2m_q;
  logic [1:0]            wbs_q, wbs_d;
  logic                  l1h_d, l2h_d, l2m_d;
  logic [Set2Bits-1:0]   vs_q, vs_d;
  logic [Tag2Bits-1:0]   vt_q, vt_d;
  logic                  vdirty;
  logic                  accept;

  logic [Set2Bits-1:0]   clr_cnt_q;
  logic [TotalBits-1:0]  totals_q [NumTotals];
  logic [TotalBits-1:0]  totals_d [NumTotals];

  logic                  out_valid_q;
  logic [OutBits-1:0]    out_data_q;
  logic                  out_load;

  // Memories
  l1_row_t               l1_mem [FirstSets];
  l2_row_t               l2_mem [SecondSets];
  l1_row_t               l1_rd_q, l1_row, l1_wdata;
  l2_row_t               l2_rd_q, l2_wdata;
  logic                  l1_init_rd_q;
  logic [FirstSets-1:0]  l1_init_q;
  logic                  l1_we, l2_we, l2_re;
  logic [Set2Bits-1:0]   l2_raddr, l2_waddr;

  logic [BlockBits-1:0]  in_blk;
  logic [Set1Bits-1:0]   s1;
  logic [Tag1Bits-1:0]   t1;
  logic [Set2Bits-1:0]   s2;
  logic [Tag2Bits-1:0]   t2;
  logic [BlockBits-1:0]  vblk;

  assign in_blk = s_axis_tdata[AddrBits-1:OffsetBits];
  assign s1     = blk_q[Set1Bits-1:0];
  assign t1     = blk_q[BlockBits-1:Set1Bits];
  assign s2     = blk_q[Set2Bits-1:0];
  assign t2     = blk_q[BlockBits-1:Set2Bits];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  // An L1 set never written reads as its reset row
  always_comb begin
    l1_row = l1_rd_q;
    if (!l1_init_rd_q) begin
      l1_row.tags  = '0;
      l1_row.valid = '0;
      l1_row.dirty = '0;
      l1_row.order = order_init();
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == Set2Bits'(SecondSets - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_LOOK;
      ST_LOOK:  state_d = (!l1h_d && vdirty) ? ST_VREQ : ST_FIN;
      ST_VREQ:  state_d = ST_VMOD;
      ST_VMOD:  state_d = ST_FIN;
      ST_FIN:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Lookup, modify and write back
  always_comb begin
    logic  hit;
    way_t  hw, vw;
    l1_row_t r1;
    l2_row_t r2;
    hit      = 1'b0;
    hw       = '0;
    vw       = '0;
    r1       = l1_row;
    r2       = l2_rd_q;
    l1h_d    = l1h_q;
    l2h_d    = l2h_q;
    l2m_d    = l2m_q;
    wbs_d    = wbs_q;
    vs_d     = vs_q;
    vt_d     = vt_q;
    vdirty   = 1'b0;
    vblk     = '0;
    l1_we    = 1'b0;
    l2_we    = 1'b0;
    l2_re    = 1'b0;
    l2_raddr = in_blk[Set2Bits-1:0];
    l2_waddr = s2;
    l1_wdata = l1_row;
    l2_wdata = l2_rd_q;
    case (state_q)
      ST_CLEAR: begin
        l2_we          = 1'b1;
        l2_waddr       = clr_cnt_q;
        l2_wdata.tags  = '0;
        l2_wdata.valid = '0;
        l2_wdata.dirty = '0;
        l2_wdata.order = order_init();
      end
      ST_IDLE: begin
        l2_re = accept;
      end
      ST_LOOK: begin
        // L1 lookup
        for (int w = NumWays - 1; w >= 0; w--) begin
          if (r1.valid[w] && r1.tags[w] == t1) begin
            hit = 1'b1;
            hw  = way_t'(w);
          end
        end
        l1h_d = hit;
        l2h_d = 1'b0;
        l2m_d = 1'b0;
        wbs_d = '0;
        l1_we = 1'b1;
        if (hit) begin
          r1.order = make_mru(r1.order, hw);
          if (wr_q) r1.dirty[hw] = 1'b1;
        end else begin
          // L2 demand lookup
          hit = 1'b0;
          hw  = '0;
          for (int w = NumWays - 1; w >= 0; w--) begin
            if (r2.valid[w] && r2.tags[w] == t2) begin
              hit = 1'b1;
              hw  = way_t'(w);
            end
          end
          l2_we = 1'b1;
          if (hit) begin
            l2h_d    = 1'b1;
            r2.order = make_mru(r2.order, hw);
          end else begin
            l2m_d     = 1'b1;
            vw        = pick_victim(r2.valid, r2.order);
            wbs_d     = {1'b0, r2.valid[vw] & r2.dirty[vw]};
            r2.valid[vw] = 1'b1;
            r2.dirty[vw] = 1'b0;
            r2.tags[vw]  = t2;
            r2.order     = make_mru(r2.order, vw);
          end
          // L1 victim and fill
          vw     = pick_victim(r1.valid, r1.order);
          vdirty = r1.valid[vw] & r1.dirty[vw];
          vblk   = {r1.tags[vw], s1};
          vs_d   = vblk[Set2Bits-1:0];
          vt_d   = vblk[BlockBits-1:Set2Bits];
          r1.valid[vw] = 1'b1;
          r1.dirty[vw] = wr_q;
          r1.tags[vw]  = t1;
          r1.order     = make_mru(r1.order, vw);
        end
        l1_wdata = r1;
        l2_wdata = r2;
      end
      ST_VREQ: begin
        l2_re    = 1'b1;
        l2_raddr = vs_q;
      end
      ST_VMOD: begin
        // Dirty victim into L2
        for (int w = NumWays - 1; w >= 0; w--) begin
          if (r2.valid[w] && r2.tags[w] == vt_q) begin
            hit = 1'b1;
            hw  = way_t'(w);
          end
        end
        if (hit) begin
          r2.dirty[hw] = 1'b1;
        end else begin
          vw           = pick_victim(r2.valid, r2.order);
          wbs_d        = wbs_q + {1'b0, r2.valid[vw] & r2.dirty[vw]};
          r2.valid[vw] = 1'b1;
          r2.dirty[vw] = 1'b1;
          r2.tags[vw]  = vt_q;
          r2.order     = make_mru(r2.order, vw);
        end
        l2_we    = 1'b1;
        l2_waddr = vs_q;
        l2_wdata = r2;
      end
      default: ;
    endcase
  end

  // Batch totals including this access
  always_comb begin
    totals_d[TotReads]    = sat_add(totals_q[TotReads],    {1'b0, !wr_q});
    totals_d[TotWrites]   = sat_add(totals_q[TotWrites],   {1'b0, wr_q});
    totals_d[TotL1Hits]   = sat_add(totals_q[TotL1Hits],   {1'b0, l1h_q});
    totals_d[TotL1Misses] = sat_add(totals_q[TotL1Misses], {1'b0, !l1h_q});
    totals_d[TotL2Hits]   = sat_add(totals_q[TotL2Hits],   {1'b0, l2h_q});
    totals_d[TotL2Misses] = sat_add(totals_q[TotL2Misses], {1'b0, l2m_q});
    totals_d[TotWbacks]   = sat_add(totals_q[TotWbacks],   wbs_q);
  end

  // L1 set memory
  always_ff @(posedge clk_i) begin
    if (l1_we) l1_mem[s1] <= l1_wdata;
    if (accept) begin
      l1_rd_q      <= l1_mem[in_blk[Set1Bits-1:0]];
      l1_init_rd_q <= l1_init_q[in_blk[Set1Bits-1:0]];
    end
  end

  // L2 set memory
  always_ff @(posedge clk_i) begin
    if (l2_we) l2_mem[l2_waddr] <= l2_wdata;
    if (l2_re) l2_rd_q <= l2_mem[l2_raddr];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wr_q   <= s_axis_tuser[0];
      last_q <= s_axis_tlast;
      blk_q  <= in_blk;
    end
    l1h_q <= l1h_d;
    l2h_q <= l2h_d;
    l2m_q <= l2m_d;
    wbs_q <= wbs_d;
    vs_q  <= vs_d;
    vt_q  <= vt_d;
    if (out_load) begin
      out_data_q <= {totals_d[TotWbacks], totals_d[TotL2Misses], totals_d[TotL2Hits],
                     totals_d[TotL1Misses], totals_d[TotL1Hits], totals_d[TotWrites],
                     totals_d[TotReads], wbs_q, l2m_q, l2h_q, l1h_q};
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      l1_init_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumTotals; i++) totals_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (l1_we) l1_init_q[s1] <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < NumTotals; i++) totals_q[i] <= last_q ? '0 : totals_d[i];
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutBytes*8-OutBits){1'b0}}, out_data_q};

endmodule
